// File: rtl/efsu_pkg.sv
// Shared constants and register codes for the frame-sync sample unpacker.
package efsu_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 51;
  localparam int unsigned CHANNELS_DEF    = 16;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned RAW_W      = 24;
  localparam int unsigned SCALED_W   = 25;
  localparam int unsigned CHAN_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned PROD_W     = RAW_W + GAIN_W + 1;
  localparam int unsigned SHIFT      = 16;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [GAIN_W-1:0] GAIN_RST        = 17'd74600;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd2;

endpackage

// File: rtl/efsu_win.sv
// Circular byte window memory with one write port and two registered read ports.
module efsu_win #(
  parameter int unsigned DEPTH = efsu_pkg::FRAME_BYTES_DEF + 2,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [efsu_pkg::BYTE_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_a_i,
  input  logic [AW-1:0]              raddr_b_i,
  output logic [efsu_pkg::BYTE_W-1:0] rdata_a_o,
  output logic [efsu_pkg::BYTE_W-1:0] rdata_b_o
);

  logic [efsu_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// File: rtl/efsu_scale.sv
// Registered gain multiplier with floor shift and saturation of the result.
module efsu_scale (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [efsu_pkg::RAW_W-1:0]   raw_i,
  input  logic [efsu_pkg::GAIN_W-1:0]         gain_i,
  output logic signed [efsu_pkg::SCALED_W-1:0] scaled_o
);

  localparam int unsigned PW = efsu_pkg::PROD_W;
  localparam int unsigned QW = PW - efsu_pkg::SHIFT;

  localparam logic signed [QW-1:0] Q_MAX = QW'((1 << (efsu_pkg::SCALED_W - 1)) - 1);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(1 << (efsu_pkg::SCALED_W - 1));

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_q;
  logic signed [QW-1:0] shifted;

  assign prod = raw_i * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod;
    end
  end

  assign shifted = prod_q[PW-1:efsu_pkg::SHIFT];

  always_comb begin
    if (shifted > Q_MAX) begin
      scaled_o = Q_MAX[efsu_pkg::SCALED_W-1:0];
    end else if (shifted < Q_MIN) begin
      scaled_o = Q_MIN[efsu_pkg::SCALED_W-1:0];
    end else begin
      scaled_o = shifted[efsu_pkg::SCALED_W-1:0];
    end
  end

endmodule

// File: rtl/eeg_frame_sync_sample_unpacker.sv
// Top level of the frame-sync deframer that unpacks 24-bit samples and scales them.
// Bytes are taken one per cycle while the window of FRAME_BYTES+2 bytes fills. Once it is
// full the sequencer examines it through the two read ports of the window memory: the
// leading header first, then the trailing header, or on a leading mismatch a header search
// that moves one byte at a time through the window. An accepted frame then goes channel by
// channel through the shared multiplier path, waiting while the output is stalled, with
// channels leaving in reverse order. The input is stalled for the whole examination.
module eeg_frame_sync_sample_unpacker #(
  parameter int unsigned FRAME_BYTES = efsu_pkg::FRAME_BYTES_DEF,
  parameter int unsigned CHANNELS    = efsu_pkg::CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [efsu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [efsu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [efsu_pkg::BYTE_W-1:0]          rx_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [efsu_pkg::CHAN_W-1:0]          channel_number_o,
  output logic signed [efsu_pkg::RAW_W-1:0]    raw_code_o,
  output logic signed [efsu_pkg::SCALED_W-1:0] scaled_value_o,
  output logic                                 last_of_frame_o
);

  localparam int unsigned WIN  = FRAME_BYTES + 2;
  localparam int unsigned AW   = $clog2(WIN);
  localparam int unsigned CW   = $clog2(WIN + 1);
  localparam int unsigned IDXW = $clog2(3 * CHANNELS + 3);
  localparam int unsigned CHW  = $clog2(CHANNELS);
  localparam int unsigned BW   = efsu_pkg::BYTE_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR0,
    ST_HDR0_CHK,
    ST_HDRF_CHK,
    ST_SRCH,
    ST_SMP_A,
    ST_SMP_B,
    ST_SMP_C,
    ST_MUL
  } state_e;

  state_e state_q, state_d;

  logic [BW-1:0]                  sync_first_q, sync_first_d;
  logic [BW-1:0]                  sync_second_q, sync_second_d;
  logic [efsu_pkg::GAIN_W-1:0]    gain_q, gain_d;
  logic [AW-1:0]                  head_q, head_d;
  logic [CW-1:0]                  fill_q, fill_d;
  logic [AW-1:0]                  srch_q, srch_d;
  logic [CHW-1:0]                 ch_q, ch_d;
  logic [BW-1:0]                  hi_q, hi_d;
  logic [BW-1:0]                  mid_q, mid_d;
  logic                           za_q, za_d;
  logic                           zb_q, zb_d;
  logic signed [efsu_pkg::RAW_W-1:0] raw_q, raw_d;
  logic                           out_valid_q, out_valid_d;
  logic [efsu_pkg::CHAN_W-1:0]    chan_out_q, chan_out_d;
  logic signed [efsu_pkg::RAW_W-1:0] raw_out_q, raw_out_d;
  logic signed [efsu_pkg::SCALED_W-1:0] scaled_out_q, scaled_out_d;
  logic                           last_out_q, last_out_d;

  logic                           we;
  logic [AW-1:0]                  waddr;
  logic [AW-1:0]                  rel_a, rel_b;
  logic [AW-1:0]                  raddr_a, raddr_b;
  logic [BW-1:0]                  rdata_a, rdata_b;
  logic                           pair_hdr;
  logic                           drop_en;
  logic [CW-1:0]                  drop_n;
  logic                           mul_en;
  logic signed [efsu_pkg::SCALED_W-1:0] scaled;
  logic [IDXW-1:0]                idx0, idx1, idx2;
  logic                           in0, in1, in2;

  function automatic logic [AW-1:0] wrap_addr(input logic [CW:0] sum);
    if (sum >= (CW + 1)'(WIN)) begin
      return AW'(sum - (CW + 1)'(WIN));
    end
    return AW'(sum);
  endfunction

  efsu_win #(
    .DEPTH (WIN),
    .AW    (AW)
  ) u_win (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (rx_byte_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  efsu_scale u_scale (
    .clk_i    (clk_i),
    .en_i     (mul_en),
    .raw_i    (raw_d),
    .gain_i   (gain_q),
    .scaled_o (scaled)
  );

  assign waddr    = wrap_addr((CW + 1)'(head_q) + (CW + 1)'(fill_q));
  assign raddr_a  = wrap_addr((CW + 1)'(head_q) + (CW + 1)'(rel_a));
  assign raddr_b  = wrap_addr((CW + 1)'(head_q) + (CW + 1)'(rel_b));
  assign pair_hdr = (rdata_a == sync_first_q) && (rdata_b == sync_second_q);

  assign idx0 = IDXW'({ch_q, 1'b0}) + IDXW'(ch_q) + IDXW'(3);
  assign idx1 = idx0 + IDXW'(1);
  assign idx2 = idx0 + IDXW'(2);
  assign in0  = int'(idx0) < FRAME_BYTES;
  assign in1  = int'(idx1) < FRAME_BYTES;
  assign in2  = int'(idx2) < FRAME_BYTES;

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign channel_number_o = chan_out_q;
  assign raw_code_o       = raw_out_q;
  assign scaled_value_o   = scaled_out_q;
  assign last_of_frame_o  = last_out_q;

  always_comb begin
    state_d       = state_q;
    sync_first_d  = sync_first_q;
    sync_second_d = sync_second_q;
    gain_d        = gain_q;
    head_d        = head_q;
    fill_d        = fill_q;
    srch_d        = srch_q;
    ch_d          = ch_q;
    hi_d          = hi_q;
    mid_d         = mid_q;
    za_d          = za_q;
    zb_d          = zb_q;
    raw_d         = raw_q;
    chan_out_d    = chan_out_q;
    raw_out_d     = raw_out_q;
    scaled_out_d  = scaled_out_q;
    last_out_d    = last_out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    we            = 1'b0;
    rel_a         = '0;
    rel_b         = '0;
    drop_en       = 1'b0;
    drop_n        = '0;
    mul_en        = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        efsu_pkg::REG_SYNC_FIRST:  sync_first_d  = cfg_wdata_i[BW-1:0];
        efsu_pkg::REG_SYNC_SECOND: sync_second_d = cfg_wdata_i[BW-1:0];
        efsu_pkg::REG_GAIN:        gain_d        = cfg_wdata_i[efsu_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          we     = 1'b1;
          fill_d = fill_q + CW'(1);
          if (fill_q == CW'(WIN - 1)) begin
            state_d = ST_HDR0;
          end
        end
      end
      ST_HDR0: begin
        rel_a   = '0;
        rel_b   = AW'(1);
        state_d = ST_HDR0_CHK;
      end
      ST_HDR0_CHK: begin
        if (pair_hdr) begin
          rel_a   = AW'(FRAME_BYTES);
          rel_b   = AW'(FRAME_BYTES + 1);
          state_d = ST_HDRF_CHK;
        end else begin
          rel_a   = AW'(1);
          rel_b   = AW'(2);
          srch_d  = AW'(1);
          state_d = ST_SRCH;
        end
      end
      ST_HDRF_CHK: begin
        if (pair_hdr) begin
          ch_d    = CHW'(CHANNELS - 1);
          state_d = ST_SMP_A;
        end else begin
          drop_en = 1'b1;
          drop_n  = CW'(2);
          state_d = ST_IDLE;
        end
      end
      ST_SRCH: begin
        if (pair_hdr) begin
          drop_en = 1'b1;
          drop_n  = CW'(srch_q);
          state_d = ST_IDLE;
        end else if (srch_q == AW'(WIN - 2)) begin
          drop_en = 1'b1;
          drop_n  = (rdata_b == sync_first_q) ? CW'(WIN - 1) : CW'(WIN);
          state_d = ST_IDLE;
        end else begin
          srch_d = srch_q + AW'(1);
          rel_a  = srch_q + AW'(1);
          rel_b  = srch_q + AW'(2);
        end
      end
      ST_SMP_A: begin
        rel_a   = in0 ? AW'(idx0) : '0;
        rel_b   = in1 ? AW'(idx1) : '0;
        za_d    = !in0;
        zb_d    = !in1;
        state_d = ST_SMP_B;
      end
      ST_SMP_B: begin
        hi_d    = za_q ? '0 : rdata_a;
        mid_d   = zb_q ? '0 : rdata_b;
        rel_a   = in2 ? AW'(idx2) : '0;
        za_d    = !in2;
        state_d = ST_SMP_C;
      end
      ST_SMP_C: begin
        raw_d   = {hi_q, mid_q, (za_q ? {BW{1'b0}} : rdata_a)};
        mul_en  = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          chan_out_d   = efsu_pkg::CHAN_W'(ch_q);
          raw_out_d    = raw_q;
          scaled_out_d = scaled;
          last_out_d   = (ch_q == '0);
          if (ch_q == '0) begin
            drop_en = 1'b1;
            drop_n  = CW'(FRAME_BYTES);
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_q - CHW'(1);
            state_d = ST_SMP_A;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (drop_en) begin
      if (drop_n >= CW'(WIN)) begin
        fill_d = '0;
      end else begin
        head_d = wrap_addr((CW + 1)'(head_q) + (CW + 1)'(drop_n));
        fill_d = CW'(WIN) - drop_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sync_first_q  <= efsu_pkg::SYNC_FIRST_RST;
      sync_second_q <= efsu_pkg::SYNC_SECOND_RST;
      gain_q        <= efsu_pkg::GAIN_RST;
      head_q        <= '0;
      fill_q        <= '0;
      srch_q        <= '0;
      ch_q          <= '0;
      za_q          <= 1'b0;
      zb_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      sync_first_q  <= sync_first_d;
      sync_second_q <= sync_second_d;
      gain_q        <= gain_d;
      head_q        <= head_d;
      fill_q        <= fill_d;
      srch_q        <= srch_d;
      ch_q          <= ch_d;
      za_q          <= za_d;
      zb_q          <= zb_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    raw_q        <= raw_d;
    chan_out_q   <= chan_out_d;
    raw_out_q    <= raw_out_d;
    scaled_out_q <= scaled_out_d;
    last_out_q   <= last_out_d;
  end

endmodule
